// ===== sv/lal_pkg.sv =====
// ----------------------------------------------------------------------------
// lal_pkg
// Shared constants, types and table-building functions for the log-average
// luminance unit.
// ----------------------------------------------------------------------------
package lal_pkg;

  localparam int unsigned MAX_FRAME_PIXELS_DEF = 1048576;
  localparam int unsigned LOG_TABLE_BITS_DEF   = 8;

  localparam int unsigned SUM_W   = 42;
  localparam int unsigned LOG_W   = 22;
  localparam int unsigned AVG_W   = 24;
  localparam int unsigned OUTC_W  = 21;
  localparam int unsigned CHAN_W  = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned EXP_N   = 16;
  localparam int unsigned FAC_W   = 31;

  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MEAN,
    ST_EXP,
    ST_OUT
  } back_state_t;

  // log2(1 + i / 2^bits) with 16 fraction bits, truncated, by repeated squaring.
  function automatic logic [15:0] log_entry(input int unsigned i, input int unsigned bits);
    longint unsigned x;
    logic [15:0] fr;
    x  = (longint'(1 << bits) + longint'(i)) << (30 - bits);
    fr = '0;
    for (int k = 0; k < 16; k++) begin
      x  = (x * x) >> 30;
      fr = {fr[14:0], 1'b0};
      if (x >= (64'd1 << 31)) begin
        fr[0] = 1'b1;
        x     = x >> 1;
      end
    end
    return fr;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned vv;
    r  = 0;
    b  = 64'd1 << 62;
    vv = v;
    for (int i = 0; i < 32; i++) begin
      if (b > vv) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (vv >= r + b) begin
          vv = vv - (r + b);
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30, each a truncated square root of the previous one.
  function automatic logic [30:0] exp_factor(input int unsigned k);
    longint unsigned c;
    c = isqrt64(64'd1 << 61);
    for (int j = 2; j <= 16; j++) begin
      if (j <= k) c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

endpackage

// ===== sv/lal_queue.sv =====
// ----------------------------------------------------------------------------
// lal_queue
// Two-entry queue carrying finished frame totals from the pixel front end to
// the mean and exponent engine.
// ----------------------------------------------------------------------------
module lal_queue #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       level_r, level_nxt;

  assign full      = (level_r == 2'd2);
  assign not_empty = (level_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    level_nxt  = level_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== sv/lal_front.sv =====
// ----------------------------------------------------------------------------
// lal_front
// Pixel front end: luminance, log2 by leading one and mantissa table, and the
// running log sum and pixel count. Frame totals are pushed on the last pixel.
// ----------------------------------------------------------------------------
module lal_front #(
  parameter int unsigned MAX_FRAME_PIXELS = lal_pkg::MAX_FRAME_PIXELS_DEF,
  parameter int unsigned LOG_TABLE_BITS   = lal_pkg::LOG_TABLE_BITS_DEF,
  localparam int unsigned CNT_W           = $clog2(MAX_FRAME_PIXELS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              red,
  input  logic [15:0]              green,
  input  logic [15:0]              blue,
  input  logic                     last_pixel,
  output logic                     push,
  input  logic                     push_full,
  output logic [lal_pkg::SUM_W-1:0] push_sum,
  output logic [CNT_W-1:0]         push_count
);

  localparam int unsigned TABLE_SIZE = 1 << LOG_TABLE_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_PIXELS);

  logic [15:0] log_tab [TABLE_SIZE];

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_tab
    assign log_tab[gi] = lal_pkg::log_entry(gi, LOG_TABLE_BITS);
  end

  logic        advance;
  logic        s1_v_r, s2_v_r, s3_v_r;
  logic        s1_last_r, s2_last_r, s3_last_r;
  logic [31:0] pr_r, pg_r, pb_r;
  logic [24:0] y1_r;
  logic [lal_pkg::LOG_W-1:0] log_r;
  logic [lal_pkg::SUM_W-1:0] sum_r, sum_add;
  logic [CNT_W-1:0]          cnt_r, cnt_add;

  logic [33:0] ysum;
  logic [24:0] y1_nxt;
  logic [4:0]  lead;
  logic [24:0] norm;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic [5:0]  expo;
  logic [lal_pkg::LOG_W-1:0] log_nxt;

  // The whole pipe holds only when a last pixel finds the queue full.
  assign advance  = !(s3_v_r && s3_last_r && push_full);
  assign in_ready = advance;

  always_comb begin
    ysum   = 34'(pr_r) + 34'(pg_r) + 34'(pb_r) + 34'd128;
    y1_nxt = 25'(ysum[33:8]) + 25'd1;
  end

  always_comb begin
    lead = '0;
    for (int t = 0; t < 25; t++) begin
      if (y1_r[t]) lead = 5'(t);
    end
    norm    = y1_r << (5'd24 - lead);
    idx     = norm[23 -: LOG_TABLE_BITS];
    expo    = 6'(lead) - 6'd16;
    log_nxt = {expo, log_tab[idx]};
  end

  always_comb begin
    sum_add = sum_r;
    cnt_add = cnt_r;
    if (cnt_r < MAX_CNT) begin
      sum_add = sum_r + {{(lal_pkg::SUM_W - lal_pkg::LOG_W){log_r[lal_pkg::LOG_W-1]}}, log_r};
      cnt_add = cnt_r + CNT_W'(1);
    end
  end

  assign push       = advance && s3_v_r && s3_last_r;
  assign push_sum   = sum_add;
  assign push_count = cnt_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else if (advance) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (s3_v_r) begin
        if (s3_last_r) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_add;
          cnt_r <= cnt_add;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pr_r      <= 32'(red) * 32'(lal_pkg::COEF_R);
      pg_r      <= 32'(green) * 32'(lal_pkg::COEF_G);
      pb_r      <= 32'(blue) * 32'(lal_pkg::COEF_B);
      s1_last_r <= last_pixel;
      y1_r      <= y1_nxt;
      s2_last_r <= s1_last_r;
      log_r     <= log_nxt;
      s3_last_r <= s2_last_r;
    end
  end

endmodule

// ===== sv/lal_back.sv =====
// ----------------------------------------------------------------------------
// lal_back
// Frame back end: rounded mean of the log sum by restoring division, then
// two to the power of the mean by one factor multiply per fraction bit.
// ----------------------------------------------------------------------------
module lal_back #(
  parameter int unsigned MAX_FRAME_PIXELS = lal_pkg::MAX_FRAME_PIXELS_DEF,
  localparam int unsigned CNT_W           = $clog2(MAX_FRAME_PIXELS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_avail,
  output logic                      pop,
  input  logic [lal_pkg::SUM_W-1:0] pop_sum,
  input  logic [CNT_W-1:0]          pop_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lal_pkg::AVG_W-1:0] average_luminance,
  output logic [CNT_W-1:0]          pixels_in_frame
);

  localparam int unsigned NUM_W = lal_pkg::SUM_W + 3;
  localparam int unsigned A_W   = lal_pkg::SUM_W + 2;
  localparam int unsigned DEN_W = CNT_W + 1;
  localparam int unsigned Q_W   = A_W + 2;

  logic [lal_pkg::FAC_W-1:0] fac [lal_pkg::EXP_N];

  for (genvar gk = 0; gk < lal_pkg::EXP_N; gk++) begin : g_fac
    assign fac[gk] = lal_pkg::exp_factor(gk + 1);
  end

  lal_pkg::back_state_t state_r, state_nxt;

  logic [A_W-1:0]   a_r, a_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [5:0]       step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [4:0]       ip_r, ip_nxt;
  logic [15:0]      f_r, f_nxt;
  logic [30:0]      x_r, x_nxt;
  logic [3:0]       k_r, k_nxt;
  logic             sat_hi_r, sat_hi_nxt;
  logic             sat_lo_r, sat_lo_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [lal_pkg::AVG_W-1:0] avg_r, avg_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [CNT_W-1:0] n_eff;
  logic [NUM_W-1:0] num;
  logic [DEN_W:0]   rem_sh;
  logic [Q_W-1:0]   q;
  logic [Q_W-1:0]   e;
  logic [61:0]      prod;
  logic [31:0]      prod_rnd;
  logic [4:0]       sh;
  logic [32:0]      fin_val;

  assign out_valid         = out_valid_r;
  assign average_luminance = avg_r;
  assign pixels_in_frame   = out_cnt_r;

  always_comb begin
    n_eff    = (pop_count == '0) ? CNT_W'(1) : pop_count;
    num      = {{2{pop_sum[lal_pkg::SUM_W-1]}}, pop_sum, 1'b0} + NUM_W'(n_eff);
    rem_sh   = {rem_r, a_r[A_W-1]};
    q        = neg_r ? -(Q_W'(a_r) + Q_W'(rem_r != '0)) : Q_W'(a_r);
    e        = q + (Q_W'(1) << 20);
    prod     = 62'(x_r) * 62'(fac[k_r]);
    prod_rnd = 32'((prod + (62'd1 << 29)) >> 30);
    sh       = 5'd30 - ip_r;
    fin_val  = (33'(x_r) + (33'd1 << (sh - 5'd1))) >> sh;
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    ip_nxt        = ip_r;
    f_nxt         = f_r;
    x_nxt         = x_r;
    k_nxt         = k_r;
    sat_hi_nxt    = sat_hi_r;
    sat_lo_nxt    = sat_lo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    avg_nxt       = avg_r;
    out_cnt_nxt   = out_cnt_r;
    pop           = 1'b0;
    unique case (state_r)
      lal_pkg::ST_IDLE: begin
        if (pop_avail) begin
          pop       = 1'b1;
          neg_nxt   = num[NUM_W-1];
          a_nxt     = A_W'(num[NUM_W-1] ? -num : num);
          den_nxt   = {n_eff, 1'b0};
          rem_nxt   = '0;
          step_nxt  = '0;
          cnt_nxt   = pop_count;
          state_nxt = lal_pkg::ST_DIV;
        end
      end
      lal_pkg::ST_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
          a_nxt   = {a_r[A_W-2:0], 1'b1};
        end else begin
          rem_nxt = DEN_W'(rem_sh);
          a_nxt   = {a_r[A_W-2:0], 1'b0};
        end
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(A_W - 1)) state_nxt = lal_pkg::ST_MEAN;
      end
      lal_pkg::ST_MEAN: begin
        sat_lo_nxt = e[Q_W-1];
        sat_hi_nxt = !e[Q_W-1] && (e >= (Q_W'(24) << 16));
        ip_nxt     = e[20:16];
        f_nxt      = e[15:0];
        x_nxt      = 31'd1 << 30;
        k_nxt      = '0;
        if (e[Q_W-1] || (e >= (Q_W'(24) << 16))) state_nxt = lal_pkg::ST_OUT;
        else state_nxt = lal_pkg::ST_EXP;
      end
      lal_pkg::ST_EXP: begin
        if (f_r[4'd15 - k_r]) x_nxt = 31'(prod_rnd);
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd15) state_nxt = lal_pkg::ST_OUT;
      end
      lal_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          if (sat_lo_r) avg_nxt = '0;
          else if (sat_hi_r || fin_val > 33'hFF_FFFF) avg_nxt = '1;
          else avg_nxt = fin_val[lal_pkg::AVG_W-1:0];
          state_nxt = lal_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lal_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lal_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    neg_r     <= neg_nxt;
    step_r    <= step_nxt;
    cnt_r     <= cnt_nxt;
    ip_r      <= ip_nxt;
    f_r       <= f_nxt;
    x_r       <= x_nxt;
    k_r       <= k_nxt;
    sat_hi_r  <= sat_hi_nxt;
    sat_lo_r  <= sat_lo_nxt;
    avg_r     <= avg_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

endmodule

// ===== sv/log_average_luminance_unit.sv =====
// ----------------------------------------------------------------------------
// log_average_luminance_unit
// Geometric mean Rec.709 luminance of a frame of Q8.8 RGB pixels, in Q8.16.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                    | tlast
//  in_     | in        | red[15:0] green[31:16] blue[47:32]     | last_pixel
//  out_    | out       | average_luminance[23:0]               | -
//          |           | pixels_in_frame[44:24], zero pad      |
//
// Pixels are taken at one per cycle, but for the stall named below, through a
// pipelined front end. Each frame then passes through the back end: it is taken
// from the queue, 44 division steps give the rounded mean, the mean is ranged,
// 16 steps of one factor multiply each form the exponent and the result is
// loaded. A mean outside the output range skips the exponent steps.
// A two-entry queue holds finished frames, so pixels keep flowing while the back
// end works; the front stalls only when a last pixel meets a full queue. Reset
// is synchronous and clears the sums and counts.
module log_average_luminance_unit #(
  parameter int unsigned MAX_FRAME_PIXELS = lal_pkg::MAX_FRAME_PIXELS_DEF,
  parameter int unsigned LOG_TABLE_BITS   = lal_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // red, green, blue
  input  logic        in_tlast,   // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // average_luminance, pixels_in_frame, zeros
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int unsigned Q_DW  = lal_pkg::SUM_W + CNT_W;

  logic                      push, q_full, pop, q_avail;
  logic [lal_pkg::SUM_W-1:0] push_sum;
  logic [CNT_W-1:0]          push_count;
  logic [Q_DW-1:0]           q_rdata;
  logic [lal_pkg::AVG_W-1:0] avg;
  logic [CNT_W-1:0]          cnt;

  lal_front #(
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS),
    .LOG_TABLE_BITS  (LOG_TABLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .red       (in_tdata[15:0]),
    .green     (in_tdata[31:16]),
    .blue      (in_tdata[47:32]),
    .last_pixel(in_tlast),
    .push      (push),
    .push_full (q_full),
    .push_sum  (push_sum),
    .push_count(push_count)
  );

  lal_queue #(.WIDTH(Q_DW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_count, push_sum}),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_avail),
    .pop_data (q_rdata)
  );

  lal_back #(.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_avail        (q_avail),
    .pop              (pop),
    .pop_sum          (q_rdata[lal_pkg::SUM_W-1:0]),
    .pop_count        (q_rdata[Q_DW-1:lal_pkg::SUM_W]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .average_luminance(avg),
    .pixels_in_frame  (cnt)
  );

  assign out_tdata = {3'b000, lal_pkg::OUTC_W'(cnt), avg};

endmodule

// ===== sv/lal_checker.sv =====
// ----------------------------------------------------------------------------
// lal_checker
// Port-level checks for the log-average luminance unit, bound to the top.
// ----------------------------------------------------------------------------
module lal_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // A waiting result must not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // With an empty pipe and queue the front end must take pixels.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // The padding above the pixel count stays clear.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:45] == 3'b000)
    else $error("nonzero padding in result");

endmodule

bind log_average_luminance_unit lal_checker u_lal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== sim/lal_checker.sv =====
// ----------------------------------------------------------------------------
// lal_scoreboard
// Watches both streams of the log-average luminance unit. It computes the
// expected frame luminance from each accepted pixel and compares each
// accepted result with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module lal_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // red, green, blue
  input  logic        in_tlast,   // last_pixel
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // average_luminance, pixels_in_frame, zeros
  output int          errors,
  output int          pending,
  output int          frames
);

  localparam int unsigned FRAME_CAP = lal_pkg::MAX_FRAME_PIXELS_DEF;
  localparam int unsigned TAB_BITS  = lal_pkg::LOG_TABLE_BITS_DEF;

  typedef struct packed {
    logic [lal_pkg::AVG_W-1:0]  lum;
    logic [lal_pkg::OUTC_W-1:0] count;
  } frame_result_t;

  frame_result_t   lum_queue[$];
  longint unsigned mant_log[1 << TAB_BITS];
  longint unsigned root_fac[17];
  longint          frame_log_sum;
  longint          frame_pixels;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  initial begin
    longint unsigned x;
    longint unsigned fr;
    for (int i = 0; i < (1 << TAB_BITS); i++) begin
      x  = (longint'(1 << TAB_BITS) + i) << (30 - TAB_BITS);
      fr = 0;
      for (int k = 0; k < 16; k++) begin
        x  = (x * x) >> 30;
        fr = fr << 1;
        if (x >= (64'd1 << 31)) begin
          fr = fr | 1;
          x  = x >> 1;
        end
      end
      mant_log[i] = fr;
    end
    root_fac[1] = int_sqrt(64'd1 << 61);
    for (int k = 2; k <= 16; k++) root_fac[k] = int_sqrt(root_fac[k-1] << 30);
  end

  function automatic longint pixel_log(input logic [47:0] rgb);
    longint unsigned y;
    int lead;
    longint unsigned idx;
    y = ((longint'(rgb[15:0]) * lal_pkg::COEF_R + longint'(rgb[31:16]) * lal_pkg::COEF_G +
          longint'(rgb[47:32]) * lal_pkg::COEF_B + 128) >> 8) + 1;
    lead = 0;
    for (int t = 0; t < 25; t++) if (y[t]) lead = t;
    if (lead >= TAB_BITS) idx = y >> (lead - TAB_BITS);
    else idx = y << (TAB_BITS - lead);
    idx = idx & ((1 << TAB_BITS) - 1);
    return longint'(lead - 16) * 65536 + longint'(mant_log[idx]);
  endfunction

  function automatic logic [lal_pkg::AVG_W-1:0] lum_from_mean(input longint m);
    longint e;
    longint unsigned x;
    int ip;
    e = m + 16 * 65536;
    if (e < 0) return '0;
    if (e >= 24 * 65536) return '1;
    ip = int'(e >> 16);
    x  = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if (e[16-k]) x = (x * root_fac[k] + (64'd1 << 29)) >> 30;
    x = (x + (64'd1 << (29 - ip))) >> (30 - ip);
    if (x > 64'hFFFFFF) x = 64'hFFFFFF;
    return x[lal_pkg::AVG_W-1:0];
  endfunction

  always @(posedge clk) begin
    longint n;
    longint num;
    longint q;
    frame_result_t got;
    frame_result_t want;
    if (!rst_n) begin
      frame_log_sum <= 0;
      frame_pixels  <= 0;
      errors        <= 0;
      frames        <= 0;
      pending       <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        n = frame_pixels;
        q = frame_log_sum;
        // Pixels beyond the frame cap add nothing to the sum or the count.
        if (n < FRAME_CAP) begin
          q = q + pixel_log(in_tdata);
          n = n + 1;
        end
        if (in_tlast) begin
          want.count = n[lal_pkg::OUTC_W-1:0];
          if (n < 1) n = 1;
          num = 2 * q + n;
          if (num >= 0) q = num / (2 * n);
          else q = -((-num + 2 * n - 1) / (2 * n));
          want.lum = lum_from_mean(q);
          lum_queue.push_back(want);
          frame_log_sum <= 0;
          frame_pixels  <= 0;
        end else begin
          frame_log_sum <= q;
          frame_pixels  <= n;
        end
      end
      if (out_tvalid && out_tready) begin
        got.lum   = out_tdata[23:0];
        got.count = out_tdata[44:24];
        frames <= frames + 1;
        if (lum_queue.size() == 0) begin
          $display("%0t: unexpected result, actual lum %0d count %0d", $time,
                   got.lum, got.count);
          errors <= errors + 1;
        end else begin
          want = lum_queue.pop_front();
          if (got.lum !== want.lum) begin
            $display("%0t: luminance mismatch, expected %0d actual %0d", $time,
                     want.lum, got.lum);
            errors <= errors + 1;
          end else if (got.count !== want.count) begin
            $display("%0t: pixel count mismatch, expected %0d actual %0d", $time,
                     want.count, got.count);
            errors <= errors + 1;
          end
        end
      end
      pending <= lum_queue.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives frames of RGB pixels into the log-average luminance unit: directed
// extremes, then random frames, with random gaps on both streams. A checker
// beside the unit predicts every result.
// ----------------------------------------------------------------------------
module tb;

  localparam longint RUN_LIMIT = 200000;
  localparam int     ITEMS     = 600;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  int          errors;
  int          pending;
  int          frames;
  longint      cycles = 0;
  int          pixels_sent;
  bit          steady;

  log_average_luminance_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  lal_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending), .frames(frames)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial out_tready = 1'b0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= steady || ($urandom_range(0, 99) >= 12);
    if (cycles > RUN_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // The first edge lets the checker count the item just accepted.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_chan();
    return 16'($urandom_range(0, 65535) >> $urandom_range(0, 16));
  endfunction

  initial begin
    int len;
    pixels_sent = 0;
    steady      = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Single-pixel frames at the extremes of each channel and at intermediate values.
    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
    send_pixel(16'h0100, 16'h0100, 16'h0100, 1'b1);
    send_pixel(16'h0001, 16'h0001, 16'h0001, 1'b1);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    // A frame mixing black and saturated pixels, giving a negative mean.
    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(16'h0000, 16'h0001, 16'h0000, 1'b1);
    // Back-to-back last pixels stress the finished-frame queue.
    for (int i = 0; i < 8; i++) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
    drain_results();

    // Random frames, mostly short; a stretch without any gaps in the middle.
    while (pixels_sent < ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      steady = (frames > 60 && frames < 90);
      for (int i = 1; i <= len; i++)
        send_pixel(rand_chan(), rand_chan(), rand_chan(), i == len);
      if (frames > 40 && frames < 46) drain_results();
    end
    steady = 1'b0;

    drain_results();
    repeat (300) @(posedge clk);
    $display("tb: %0d pixels sent in %0d frames, single-pixel extremes and random frames",
             pixels_sent, frames);
    $display("tb: both streams stalled at random, with one gap-free stretch and drains");
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== log_average_luminance_unit.f =====
sv/lal_pkg.sv
sv/lal_queue.sv
sv/lal_front.sv
sv/lal_back.sv
sv/log_average_luminance_unit.sv
sv/lal_checker.sv
sim/lal_checker.sv
sim/tb.sv
